/* design/fle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_pkg
// Shared types for the line FIR filter: controller states, the command
// bundle to the datapath and the status bundle back.
// ----------------------------------------------------------------------------
package fle_pkg;

    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int HALF_W = 4;
    localparam int CIDX_W = 5;
    localparam int CNT_W  = 16;
    localparam int RND_BIAS  = 16384;
    localparam int RND_SHIFT = 15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_SHIFT,
        S_CLR,
        S_MAC,
        S_MEND,
        S_RND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;      // take a pixel item into the window
        logic plan;      // set flush and shift counts
        logic shift;     // replicate the last pixel once
        logic reload;    // one shift before the next flush output
        logic clr;       // clear accumulator and tap counter
        logic mac;       // issue one product
        logic drain;     // add the final product
        logic rnd;       // round, saturate, load output register
        logic end_line;  // close the line
    } t_cmd;

    typedef struct packed {
        logic emit;        // push count exceeds half length
        logic last;        // current pixel ends the line
        logic shift_done;  // one shift left
        logic mac_last;    // last tap being issued
        logic more;        // flush outputs remain
    } t_status;

endpackage
`default_nettype wire

/* design/fir_line_filter_edge_replicate.sv */
// Order (h = half length): a pixel item with an output runs plan, clear, tap
//   loop, drain, round and output; each further end-of-line output runs one
//   shift and these again, a short line's first flush up to h-1 extra shifts.
// Throughput: one item at a time; a coefficient write is taken in idle, a
//   pixel without output passes the plan state, a pixel with output runs the
//   tap loop on the single shared tap multiplier; output stalls add to these.
// Reset: synchronous, active low; clears window, taps, line state, and sets
//   half length to 1.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_line_filter_edge_replicate
// Odd-length line FIR with edge replication, rounded and saturated output.
// ----------------------------------------------------------------------------
module fir_line_filter_edge_replicate #(
    parameter int MAX_TAPS = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [4:0]  i_coef_index,
    input  wire logic [15:0] i_coef_value,
    input  wire logic [15:0] i_pixel_in,
    input  wire logic        i_last_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel_out,
    output logic             o_last_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [3:0]  i_cfg_wr_data
);
    import fle_pkg::*;

    t_cmd    cmd;
    t_status status;

    // controller
    fle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_stall     (i_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // datapath
    fle_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_coef_we     (i_valid && !o_stall && !i_kind),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_pixel_in    (i_pixel_in),
        .i_last_in     (i_last_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_status      (status),
        .o_pixel_out   (o_pixel_out),
        .o_last_out    (o_last_out)
    );

`ifndef ASSERT_OFF
    // no input taken while a result is offered
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken during output");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out)
            && $stable(o_last_out)) else $error("output changed under stall");

    // input is stalled right after a pixel item is taken
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind |=> o_stall) else $error("pixel not held");
`endif

endmodule
`default_nettype wire

/* design/fle_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_ctrl
// Sequencer: load a pixel, run the tap loop, emit outputs, replicate the
// last pixel through the end-of-line flush.
// ----------------------------------------------------------------------------
module fle_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_kind,
    input  wire logic             i_stall,
    input  wire fle_pkg::t_status i_status,
    output fle_pkg::t_cmd         o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);
    import fle_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_kind) n_state = S_PLAN;
            end
            S_PLAN: begin
                if (i_status.emit) n_state = S_CLR;
                else if (i_status.last) n_state = S_SHIFT;
                else n_state = S_IDLE;
            end
            S_SHIFT: begin
                if (i_status.shift_done) n_state = S_CLR;
            end
            S_CLR:  n_state = S_MAC;
            S_MAC: begin
                if (i_status.mac_last) n_state = S_MEND;
            end
            S_MEND: n_state = S_RND;
            S_RND:  n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) n_state = i_status.more ? S_SHIFT : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_valid && i_kind;
            end
            S_PLAN: begin
                o_cmd.plan     = 1'b1;
                o_cmd.end_line = !i_status.emit && !i_status.last;
            end
            S_SHIFT: o_cmd.shift = 1'b1;
            S_CLR:   o_cmd.clr   = 1'b1;
            S_MAC:   o_cmd.mac   = 1'b1;
            S_MEND:  o_cmd.drain = 1'b1;
            S_RND:   o_cmd.rnd   = 1'b1;
            S_OUT: begin
                o_out_valid    = 1'b1;
                o_cmd.reload   = !i_stall && i_status.more;
                o_cmd.end_line = !i_stall && !i_status.more;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* design/fle_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fle_dp
// Datapath: window shift register, tap store, one shared multiplier with
// accumulator, rounding and saturation, line and flush counters.
// ----------------------------------------------------------------------------
module fle_dp #(
    parameter int MAX_TAPS = 31
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fle_pkg::t_cmd        i_cmd,
    input  wire logic                 i_coef_we,
    input  wire logic [4:0]           i_coef_index,
    input  wire logic [15:0]          i_coef_value,
    input  wire logic [15:0]          i_pixel_in,
    input  wire logic                 i_last_in,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [3:0]           i_cfg_wr_data,
    output fle_pkg::t_status          o_status,
    output logic [15:0]               o_pixel_out,
    output logic                      o_last_out
);
    import fle_pkg::*;

    localparam int IW   = $clog2(MAX_TAPS);
    localparam int HLIM = (MAX_TAPS - 1) / 2;
    localparam int AW   = 32 + IW;

    logic [PIX_W-1:0]  r_win [MAX_TAPS];
    logic [COEF_W-1:0] r_tap [MAX_TAPS];
    logic [HALF_W-1:0] r_half_taps;
    logic              r_in_line;
    logic [CNT_W-1:0]  r_cnt;
    logic [PIX_W-1:0]  r_px;
    logic              r_last;
    logic              r_flushing;
    logic [4:0]        r_flush_left;
    logic [4:0]        r_shift_left;
    logic [4:0]        r_k;
    logic [31:0]       r_prod;
    logic              r_pv;
    logic [AW-1:0]     r_acc;
    logic [15:0]       r_pixel_out;
    logic              r_last_out;

    logic [HALF_W-1:0] h;
    logic [4:0]        two_h;
    logic [IW+4:0]     widx;
    logic [IW+4:0]     tidx;
    logic [IW+4:0]     cidx;
    logic [AW:0]       rsum;
    logic [AW:0]       rq;
    logic [4:0]        fl_next;
    logic              emit;

    // limit half length to the window
    assign h     = (32'(r_half_taps) > HLIM) ? HALF_W'(HLIM) : r_half_taps;
    assign two_h = {h, 1'b0};
    assign widx  = (IW+5)'(two_h) - (IW+5)'(r_k);
    assign tidx  = (IW+5)'(r_k);
    assign cidx  = (IW+5)'(i_coef_index);
    assign emit  = r_cnt > CNT_W'(h);

    // half length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_taps <= HALF_W'(1);
        end else if (i_cfg_wr_en) begin
            r_half_taps <= i_cfg_wr_data;
        end
    end

    // tap store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) r_tap[i] <= '0;
        end else if (i_coef_we && (32'(cidx) < MAX_TAPS)) begin
            r_tap[cidx[IW-1:0]] <= i_coef_value;
        end
    end

    // window: fill on first pixel, shift on later and replicated pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) r_win[i] <= '0;
        end else if (i_cmd.load && !r_in_line) begin
            for (int i = 0; i < MAX_TAPS; i++) r_win[i] <= i_pixel_in;
        end else if (i_cmd.load || i_cmd.shift) begin
            for (int i = MAX_TAPS - 1; i > 0; i--) r_win[i] <= r_win[i-1];
            r_win[0] <= i_cmd.load ? i_pixel_in : r_px;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_line <= 1'b0;
            r_cnt     <= '0;
        end else if (i_cmd.load) begin
            r_in_line <= 1'b1;
            if (!r_in_line) r_cnt <= CNT_W'(1);
            else if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.end_line && r_last) begin
            r_in_line <= 1'b0;
            r_cnt     <= '0;
        end
    end

    // pixel and flush bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px         <= '0;
            r_last       <= 1'b0;
            r_flushing   <= 1'b0;
            r_flush_left <= '0;
            r_shift_left <= '0;
        end else begin
            if (i_cmd.load) begin
                r_px       <= i_pixel_in;
                r_last     <= i_last_in;
                r_flushing <= 1'b0;
            end
            if (i_cmd.plan) begin
                if (emit) begin
                    r_flush_left <= 5'(h);
                    r_shift_left <= 5'd1;
                end else begin
                    r_flush_left <= r_cnt[4:0];
                    r_shift_left <= 5'(h) - r_cnt[4:0] + 5'd1;
                end
            end
            if (i_cmd.shift) begin
                r_flushing   <= 1'b1;
                r_shift_left <= r_shift_left - 5'd1;
            end
            if (i_cmd.reload) r_shift_left <= 5'd1;
            if (i_cmd.rnd && r_flushing) r_flush_left <= fl_next;
        end
    end

    // multiply and accumulate, one tap a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_k   <= '0;
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_prod <= r_tap[tidx[IW-1:0]] * r_win[widx[IW-1:0]];
            r_pv   <= 1'b1;
            r_k    <= r_k + 5'd1;
            if (r_pv) r_acc <= r_acc + AW'(r_prod);
        end else if (i_cmd.drain) begin
            r_acc <= r_acc + AW'(r_prod);
            r_pv  <= 1'b0;
        end
    end

    // round half up, saturate
    assign rsum    = (AW+1)'(r_acc) + (AW+1)'(RND_BIAS);
    assign rq      = rsum >> RND_SHIFT;
    assign fl_next = r_flush_left - 5'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd) begin
            r_pixel_out <= (rq > (AW+1)'(16'hFFFF)) ? 16'hFFFF : rq[15:0];
            r_last_out  <= r_last && (r_flushing ? (fl_next == '0)
                                                 : (r_flush_left == '0));
        end
    end

    assign o_pixel_out         = r_pixel_out;
    assign o_last_out          = r_last_out;
    assign o_status.emit       = emit;
    assign o_status.last       = r_last;
    assign o_status.shift_done = (r_shift_left == 5'd1);
    assign o_status.mac_last   = (r_k == two_h);
    assign o_status.more       = r_last && (r_flush_left != '0);

endmodule
`default_nettype wire
